/* src/icq_pkg.sv */
// ============================================================================
// icq_pkg: shared types and constants for the cut table and piece query unit
// Sizes of the cell chain, status codes, command codes and the control bundle
// that the sequencer broadcasts to every cell, and the reduced result bundle.
// ============================================================================
package icq_pkg;

    localparam int CAPACITY      = 256;
    localparam int POSITION_BITS = 30;
    localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
    localparam int GROUP_SIZE    = 16;
    localparam int GROUP_COUNT   = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int TDATA_BITS    = ((POSITION_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef enum logic {
        CMD_CUT   = 1'b0,
        CMD_QUERY = 1'b1
    } command_t;

    // Broadcast from the sequencer to all cells.
    typedef struct packed {
        logic                     insert;
        logic [POSITION_BITS-1:0] pos;
        logic [POSITION_BITS-1:0] seg;
        logic [COUNT_BITS-1:0]    count;
    } icq_ctrl_t;

    // Reduced answer of the chain back to the sequencer.
    typedef struct packed {
        logic                     hit_any;
        logic                     right_hit;
        logic [POSITION_BITS-1:0] left;
        logic [POSITION_BITS-1:0] right;
    } icq_result_t;

endpackage

/* src/interval_cut_and_length_query_unit.sv */
// ============================================================================
// interval_cut_and_length_query_unit: sorted cut table with piece queries
// Inserts cut points into a sorted chain of cells and answers the length of
// the piece of the segment that contains a queried position.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser: command; tdata: position
//   m_axis    out        tuser: status; tdata: piece_length
//   cfg_wr    in         segment_length
//
// Each request passes through accept, compare in every cell, one level of the
// registered OR tree with the insert shift, and the result register load.
// A new request is taken while a finished result still waits on m_axis.
// Reset is synchronous: it empties the table and sets the full segment length.
// A stalled result holds the sequencer in its last step until it is taken.
// ============================================================================
module interval_cut_and_length_query_unit import icq_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Configuration
    input  logic                     cfg_wr_en,
    input  logic [POSITION_BITS-1:0] cfg_wr_data,   // segment_length
    // Request channel
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [TDATA_BITS-1:0]    s_axis_tdata,  // [29:0] position, rest zero
    input  logic                     s_axis_tuser,  // [0] command
    // Result channel
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [TDATA_BITS-1:0]    m_axis_tdata,  // [29:0] piece_length, rest zero
    output logic [1:0]               m_axis_tuser   // [1:0] status
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVAL   = 4'b0010,
        ST_REDUCE = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [POSITION_BITS-1:0] seg_reg, seg_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    command_t                 cmd_reg, cmd_next;
    logic                     clamp_reg, clamp_next;
    status_t                  status_reg, status_next;
    logic                     m_valid_reg, m_valid_next;
    logic [POSITION_BITS-1:0] m_length_reg, m_length_next;
    status_t                  m_status_reg, m_status_next;

    logic                     accept;
    logic                     load;
    logic [POSITION_BITS-1:0] in_pos;
    command_t                 in_cmd;
    status_t                  cut_status;
    logic [POSITION_BITS-1:0] right_bound;
    icq_ctrl_t                ctrl;
    icq_result_t              result;

    assign in_pos = s_axis_tdata[POSITION_BITS-1:0];
    assign in_cmd = command_t'(s_axis_tuser);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load          = (state_reg == ST_FINISH) && (!m_valid_reg || m_axis_tready);

    // Cut check: range and duplicate first, then capacity.
    always_comb begin
        if (pos_reg == '0 || pos_reg >= seg_reg || result.hit_any) begin
            cut_status = STATUS_INVALID;
        end else if (count_reg == COUNT_BITS'(CAPACITY)) begin
            cut_status = STATUS_FULL;
        end else begin
            cut_status = STATUS_OK;
        end
    end

    always_comb begin
        ctrl.insert = (state_reg == ST_REDUCE) && (cmd_reg == CMD_CUT)
                      && (cut_status == STATUS_OK);
        ctrl.pos    = pos_reg;
        ctrl.seg    = seg_reg;
        ctrl.count  = count_reg;
    end

    icq_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .result  (result)
    );

    assign right_bound = result.right_hit ? result.right : seg_reg;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) begin
                state_next = ST_EVAL;
            end
            ST_EVAL:   state_next = ST_REDUCE;
            ST_REDUCE: state_next = ST_FINISH;
            ST_FINISH: if (load) begin
                state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Request capture; a query beyond the segment is clamped to its end.
    always_comb begin
        pos_next   = pos_reg;
        cmd_next   = cmd_reg;
        clamp_next = clamp_reg;
        if (accept) begin
            cmd_next   = in_cmd;
            clamp_next = (in_cmd == CMD_QUERY) && (in_pos > seg_reg);
            pos_next   = clamp_next ? seg_reg : in_pos;
        end
    end

    // Table fill count and cut status.
    always_comb begin
        count_next  = count_reg;
        status_next = status_reg;
        if (state_reg == ST_REDUCE) begin
            status_next = cut_status;
        end
        if (ctrl.insert) begin
            count_next = count_reg + COUNT_BITS'(1);
        end
    end

    assign seg_next = cfg_wr_en ? cfg_wr_data : seg_reg;

    // Result register.
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_length_next = m_length_reg;
        m_status_next = m_status_reg;
        if (load) begin
            m_valid_next = 1'b1;
            if (cmd_reg == CMD_QUERY) begin
                m_length_next = right_bound - result.left;
                m_status_next = clamp_reg ? STATUS_INVALID : STATUS_OK;
            end else begin
                m_length_next = '0;
                m_status_next = status_reg;
            end
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            seg_reg     <= '1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            seg_reg     <= seg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        cmd_reg      <= cmd_next;
        clamp_reg    <= clamp_next;
        status_reg   <= status_next;
        m_length_reg <= m_length_next;
        m_status_reg <= m_status_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = TDATA_BITS'(m_length_reg);
    assign m_axis_tuser  = m_status_reg;

endmodule

/* src/icq_cell.sv */
// ============================================================================
// icq_cell: one slot of the sorted cut chain
// Holds one cut point, compares it with the broadcast position, shifts in its
// left neighbor's value or the new point on an insert, and registers its share of the query.
// ============================================================================
module icq_cell import icq_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  icq_ctrl_t                ctrl,
    input  logic                     cell_valid,
    input  logic [POSITION_BITS-1:0] prev_value,
    input  logic                     prev_keep,
    input  logic                     prev_gt,
    input  logic                     next_le,
    output logic [POSITION_BITS-1:0] value,
    output logic                     keep,
    output logic                     le,
    output logic                     gt,
    output logic [POSITION_BITS-1:0] left_val,
    output logic [POSITION_BITS-1:0] right_val,
    output logic                     right_hit,
    output logic                     eq_hit
);

    logic [POSITION_BITS-1:0] value_reg, value_next;
    logic [POSITION_BITS-1:0] left_reg, left_next;
    logic [POSITION_BITS-1:0] right_reg, right_next;
    logic                     right_hit_reg, right_hit_next;
    logic                     eq_reg, eq_next;
    logic                     below_seg;

    // Compare the stored cut with the position and the segment end.
    always_comb begin
        below_seg = value_reg < ctrl.seg;
        keep      = cell_valid && (value_reg < ctrl.pos);
        le        = cell_valid && below_seg && (value_reg <= ctrl.pos);
        gt        = cell_valid && below_seg && (value_reg > ctrl.pos);
        eq_next   = cell_valid && (value_reg == ctrl.pos);
    end

    // The last cut at or below the position and the first cut above it.
    always_comb begin
        right_hit_next = gt && !prev_gt;
        left_next      = (le && !next_le) ? value_reg : '0;
        right_next     = right_hit_next ? value_reg : '0;
    end

    // Insertion: cells below the new point keep their value, the first cell
    // above takes the point, the rest take their left neighbor's value.
    always_comb begin
        value_next = value_reg;
        if (ctrl.insert && !keep) begin
            value_next = prev_keep ? ctrl.pos : prev_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_hit_reg <= 1'b0;
            eq_reg        <= 1'b0;
        end else begin
            right_hit_reg <= right_hit_next;
            eq_reg        <= eq_next;
        end
    end

    assign value     = value_reg;
    assign left_val  = left_reg;
    assign right_val = right_reg;
    assign right_hit = right_hit_reg;
    assign eq_hit    = eq_reg;

endmodule

/* src/icq_chain.sv */
// ============================================================================
// icq_chain: row of cut cells with a registered reduction tree
// Links the cells to their neighbors and folds the per-cell query shares
// into one left bound, one right bound, a right-hit flag and a duplicate flag.
// ============================================================================
module icq_chain import icq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  icq_ctrl_t   ctrl,
    output icq_result_t result
);

    logic [CAPACITY-1:0][POSITION_BITS-1:0] value;
    logic [CAPACITY-1:0][POSITION_BITS-1:0] left_val;
    logic [CAPACITY-1:0][POSITION_BITS-1:0] right_val;
    logic [CAPACITY-1:0]                    keep;
    logic [CAPACITY-1:0]                    le;
    logic [CAPACITY-1:0]                    gt;
    logic [CAPACITY-1:0]                    right_hit;
    logic [CAPACITY-1:0]                    eq_hit;

    logic [GROUP_COUNT-1:0][POSITION_BITS-1:0] grp_left_reg, grp_left_next;
    logic [GROUP_COUNT-1:0][POSITION_BITS-1:0] grp_right_reg, grp_right_next;
    logic [GROUP_COUNT-1:0]                    grp_hit_reg, grp_hit_next;

    // Cells, each wired to its left and right neighbor.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [POSITION_BITS-1:0] prev_value;
        logic                     prev_keep;
        logic                     prev_gt;
        logic                     next_le;
        logic                     cell_valid;

        if (i == 0) begin : g_first
            assign prev_value = ctrl.pos;
            assign prev_keep  = 1'b1;
            assign prev_gt    = 1'b0;
        end else begin : g_inner
            assign prev_value = value[i-1];
            assign prev_keep  = keep[i-1];
            assign prev_gt    = gt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign next_le = 1'b0;
        end else begin : g_body
            assign next_le = le[i+1];
        end

        assign cell_valid = COUNT_BITS'(i) < ctrl.count;

        icq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .cell_valid (cell_valid),
            .prev_value (prev_value),
            .prev_keep  (prev_keep),
            .prev_gt    (prev_gt),
            .next_le    (next_le),
            .value      (value[i]),
            .keep       (keep[i]),
            .le         (le[i]),
            .gt         (gt[i]),
            .left_val   (left_val[i]),
            .right_val  (right_val[i]),
            .right_hit  (right_hit[i]),
            .eq_hit     (eq_hit[i])
        );
    end

    // First level of the tree: OR each group of cell shares.
    always_comb begin
        grp_left_next  = '0;
        grp_right_next = '0;
        grp_hit_next   = '0;
        for (int g = 0; g < GROUP_COUNT; g++) begin
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < CAPACITY) begin
                    grp_left_next[g]  = grp_left_next[g]  | left_val[g * GROUP_SIZE + k];
                    grp_right_next[g] = grp_right_next[g] | right_val[g * GROUP_SIZE + k];
                    grp_hit_next[g]   = grp_hit_next[g]   | right_hit[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_left_reg  <= grp_left_next;
        grp_right_reg <= grp_right_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_hit_reg <= '0;
        end else begin
            grp_hit_reg <= grp_hit_next;
        end
    end

    // Final level over the group registers; the duplicate flag ORs the cell flags directly.
    always_comb begin
        result.hit_any   = |eq_hit;
        result.right_hit = |grp_hit_reg;
        result.left      = '0;
        result.right     = '0;
        for (int g = 0; g < GROUP_COUNT; g++) begin
            result.left  = result.left  | grp_left_reg[g];
            result.right = result.right | grp_right_reg[g];
        end
    end

endmodule
